FILE: rtl/core/cj188_fr_pkg.sv
`default_nettype none

package cj188_fr_pkg;

  // register file indexes
  typedef enum logic [1:0] {
    CFG_METER_TYPE  = 2'd0,
    CFG_START_CODE  = 2'd1,
    CFG_END_CODE    = 2'd2,
    CFG_BYTE_BUDGET = 2'd3
  } cfg_idx_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_HUNTING    = 3'd0,
    ST_COLLECTING = 3'd1,
    ST_ACCEPTED   = 3'd2,
    ST_RESYNC     = 3'd3,
    ST_BAD_END    = 3'd4,
    ST_BUDGET_OUT = 3'd5,
    ST_TIMEOUT    = 3'd6
  } status_e;

  localparam int unsigned ADDR_BYTES_DEF = 7;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned POS_W          = 9;

  localparam logic [7:0]  METER_TYPE_RST  = 8'd16;
  localparam logic [7:0]  START_CODE_RST  = 8'd104;
  localparam logic [7:0]  END_CODE_RST    = 8'd22;
  localparam logic [15:0] BYTE_BUDGET_RST = 16'd500;

  typedef struct packed {
    logic [7:0]  meter_type;
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [15:0] byte_budget;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [7:0]       frame_byte;
    logic             byte_in_frame;
    logic [POS_W-1:0] byte_position;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/cj188_fr_cfg.sv
`default_nettype none

module cj188_fr_cfg
  import cj188_fr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_METER_TYPE:  cfg_d.meter_type  = cfg_data_i[7:0];
        CFG_START_CODE:  cfg_d.start_code  = cfg_data_i[7:0];
        CFG_END_CODE:    cfg_d.end_code    = cfg_data_i[7:0];
        CFG_BYTE_BUDGET: cfg_d.byte_budget = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.meter_type  <= METER_TYPE_RST;
      cfg_q.start_code  <= START_CODE_RST;
      cfg_q.end_code    <= END_CODE_RST;
      cfg_q.byte_budget <= BYTE_BUDGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/cj188_fr_parser.sv
`default_nettype none

module cj188_fr_parser
  import cj188_fr_pkg::*;
#(
  parameter int unsigned ADDR_BYTES = ADDR_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  cfg_t            cfg_i,
  input  wire logic       step_i,
  input  wire logic       kind_i,
  input  wire logic [7:0] rx_byte_i,
  output res_t            res_o
);

  localparam int unsigned ACNT_W = $clog2(ADDR_BYTES + 1);

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_TYPE = 8'b0000_0010,
    PH_ADDR = 8'b0000_0100,
    PH_CTRL = 8'b0000_1000,
    PH_LEN  = 8'b0001_0000,
    PH_DATA = 8'b0010_0000,
    PH_CSUM = 8'b0100_0000,
    PH_END  = 8'b1000_0000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ACNT_W-1:0] acnt_q, acnt_d;
  logic [7:0]        dlen_q, dlen_d;
  logic [7:0]        dcnt_q, dcnt_d;
  logic [7:0]        sum_q, sum_d;
  logic [POS_W-1:0]  fpos_q, fpos_d;
  logic [15:0]       budget_q, budget_d;

  logic             kept, finished;
  logic [POS_W-1:0] base_pos;
  logic [7:0]       base_sum;
  logic [8:0]       dcnt_inc;

  // a start byte opens a fresh frame regardless of leftovers from a resync
  assign base_pos = (phase_q == PH_HUNT) ? '0 : fpos_q;
  assign base_sum = (phase_q == PH_HUNT) ? '0 : sum_q;
  assign dcnt_inc = {1'b0, dcnt_q} + 9'd1;

  always_comb begin
    phase_d  = phase_q;
    acnt_d   = acnt_q;
    dlen_d   = dlen_q;
    dcnt_d   = dcnt_q;
    sum_d    = sum_q;
    fpos_d   = fpos_q;
    budget_d = budget_q;
    kept     = 1'b0;
    finished = 1'b0;

    res_o.status        = ST_COLLECTING;
    res_o.frame_byte    = rx_byte_i;
    res_o.byte_in_frame = 1'b0;
    res_o.byte_position = '0;

    if (kind_i) begin
      res_o.status     = ST_TIMEOUT;
      res_o.frame_byte = '0;
      finished         = 1'b1;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == cfg_i.start_code) begin
            kept    = 1'b1;
            phase_d = PH_TYPE;
          end else begin
            res_o.status = ST_HUNTING;
          end
        end
        PH_TYPE: begin
          if (rx_byte_i == cfg_i.meter_type) begin
            kept    = 1'b1;
            acnt_d  = '0;
            phase_d = PH_ADDR;
          end else begin
            res_o.status = ST_HUNTING;
            phase_d      = PH_HUNT;
          end
        end
        PH_ADDR: begin
          kept   = 1'b1;
          acnt_d = acnt_q + 1'b1;
          if (acnt_q == ACNT_W'(ADDR_BYTES - 1)) begin
            phase_d = PH_CTRL;
          end
        end
        PH_CTRL: begin
          kept    = 1'b1;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          kept    = 1'b1;
          dlen_d  = rx_byte_i;
          dcnt_d  = '0;
          phase_d = (rx_byte_i != 8'd0) ? PH_DATA : PH_CSUM;
        end
        PH_DATA: begin
          kept   = 1'b1;
          dcnt_d = dcnt_inc[7:0];
          if (dcnt_inc >= {1'b0, dlen_q}) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          // checksum byte is stored but not summed
          res_o.byte_in_frame = 1'b1;
          res_o.byte_position = fpos_q;
          fpos_d              = fpos_q + 1'b1;
          if (rx_byte_i == sum_q) begin
            phase_d = PH_END;
          end else begin
            res_o.status = ST_RESYNC;
            phase_d      = PH_HUNT;
          end
        end
        PH_END: begin
          res_o.byte_in_frame = 1'b1;
          res_o.byte_position = fpos_q;
          res_o.status = (rx_byte_i == cfg_i.end_code) ? ST_ACCEPTED : ST_BAD_END;
          finished     = 1'b1;
        end
        default: begin
          res_o.status = ST_HUNTING;
          phase_d      = PH_HUNT;
        end
      endcase

      if (kept) begin
        res_o.byte_in_frame = 1'b1;
        res_o.byte_position = base_pos;
        fpos_d              = base_pos + 1'b1;
        sum_d               = base_sum + rx_byte_i;
      end

      // last budget unit overrides any status except a frame end
      if (!finished) begin
        if (budget_q <= 16'd1) begin
          res_o.status = ST_BUDGET_OUT;
          finished     = 1'b1;
        end else begin
          budget_d = budget_q - 16'd1;
        end
      end
    end

    if (finished) begin
      phase_d  = PH_HUNT;
      acnt_d   = '0;
      dlen_d   = '0;
      dcnt_d   = '0;
      sum_d    = '0;
      fpos_d   = '0;
      budget_d = cfg_i.byte_budget;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      acnt_q   <= '0;
      dlen_q   <= '0;
      dcnt_q   <= '0;
      sum_q    <= '0;
      fpos_q   <= '0;
      budget_q <= BYTE_BUDGET_RST;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acnt_q   <= acnt_d;
      dlen_q   <= dlen_d;
      dcnt_q   <= dcnt_d;
      sum_q    <= sum_d;
      fpos_q   <= fpos_d;
      budget_q <= budget_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cj188_frame_receiver_unit.sv
`default_nettype none

// cj188 meter reply frame receiver. each input transaction carries either a
// received byte (tuser 0) or a receive timeout event (tuser 1) and produces
// exactly one output transaction echoing the byte with its status and its
// position in the candidate frame. frame layout: start byte, meter type,
// ADDR_BYTES address bytes, control, length L, L data bytes, checksum (sum
// mod 256 of start byte through last data byte), end byte. throughput is one
// transaction per clock while the result side is ready; an accepted
// transaction sits in the input register, the single-pass parser step
// decides it and the result register takes it once that register is free
// or being drained, and the result is offered from the result register. a
// stalled result stream holds the result register, then the input register,
// and only then drops s_tready_o. the register file (meter type, start code,
// end code, byte budget) is to be written by the user through the plain write
// port only while no transaction is in flight; the block does not enforce
// this. a new byte budget takes effect when the next receive attempt starts.

module cj188_frame_receiver_unit
  import cj188_fr_pkg::*;
#(
  parameter int unsigned ADDR_BYTES = ADDR_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [7:0]            s_tdata_i,   // [7:0] rx_byte
  input  wire logic                  s_tuser_i,   // [0] kind
  // result stream
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [23:0]                m_tdata_o,   // [7:0] frame_byte, [16:8] byte_position
  output logic [3:0]                 m_tuser_o,   // [2:0] status, [3] byte_in_frame
  // register write port
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;
  res_t res;

  // input register
  logic       in_valid_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;

  // result register
  logic out_valid_q;
  res_t out_res_q;

  logic advance;

  // the step fires when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  // payload holds until the next accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_kind_q <= s_tuser_i;
      in_byte_q <= s_tdata_i;
    end
  end

  cj188_fr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cj188_fr_parser #(
    .ADDR_BYTES (ADDR_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .kind_i    (in_kind_q),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'd0, out_res_q.byte_position, out_res_q.frame_byte};
  assign m_tuser_o  = {out_res_q.byte_in_frame, out_res_q.status};

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import cj188_fr_pkg::*;

  // parser phases of the frame predictor
  typedef enum logic [3:0] {
    FP_HUNT, FP_TYPE, FP_ADDR, FP_CTRL, FP_LEN, FP_DATA, FP_CSUM, FP_END
  } fr_phase_e;

  // ways a generated frame can be damaged
  typedef enum int {
    FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_BAD_TYPE, FR_CUT
  } frame_fault_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_item_t;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;
  localparam int   LATENCY      = 4;       // two register stages plus margin
  localparam int   MAX_SHOWN    = 40;      // mismatch lines printed at most

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  // dut ports, all known from time zero
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [7:0]            s_tdata_i  = '0;
  logic                  s_tuser_i  = KIND_BYTE;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [23:0]           m_tdata_o;
  logic [3:0]            m_tuser_o;
  logic                  cfg_we_i   = 1'b0;
  logic [1:0]            cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  cj188_frame_receiver_unit #(
    .ADDR_BYTES(ADDR_BYTES_DEF)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),   // [7:0] rx_byte
    .s_tuser_i (s_tuser_i),   // [0] kind
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),   // [7:0] frame_byte, [16:8] byte_position
    .m_tuser_o (m_tuser_o),   // [2:0] status, [3] byte_in_frame
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // register copy as the dut should hold it
  cfg_t reg_cfg = '{METER_TYPE_RST, START_CODE_RST, END_CODE_RST, BYTE_BUDGET_RST};

  // frame parser state of the predictor
  fr_phase_e   fr_phase;
  logic [3:0]  addr_cnt;
  logic [7:0]  data_len;
  logic [8:0]  data_cnt;
  logic [7:0]  run_sum;
  logic [8:0]  frame_pos;
  logic [15:0] budget_left;

  // stimulus and scoreboard storage
  rx_item_t rx_pending[$];      // bytes and timeouts waiting to be sent
  res_t     expected_res[$];    // results predicted for accepted transactions
  rx_item_t next_rx;
  int unsigned n_queued   = 0;
  int          in_flight  = 0;  // popped from rx_pending, result not yet checked
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;  // no idling on either side while set
  int unsigned n_err      = 0;
  int unsigned n_checked  = 0;
  int unsigned n_settings = 1;
  int unsigned n_status[7];

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  // end of an attempt: back to hunting, budget reloaded from the register
  function automatic void restart_attempt();
    fr_phase    = FP_HUNT;
    addr_cnt    = '0;
    data_len    = '0;
    data_cnt    = '0;
    run_sum     = '0;
    frame_pos   = '0;
    budget_left = reg_cfg.byte_budget;
  endfunction

  function automatic res_t parse_rx(input logic kind, input logic [7:0] b);
    res_t      r;
    status_e   st;
    logic      kept;
    logic      stored;
    logic      done;
    logic [8:0] pos;
    st     = ST_COLLECTING;
    kept   = 1'b0;
    stored = 1'b0;
    done   = 1'b0;
    pos    = '0;
    // a timeout always ends the attempt and reports nothing stored
    if (kind == KIND_TIMEOUT) begin
      r.status        = ST_TIMEOUT;
      r.frame_byte    = '0;
      r.byte_in_frame = 1'b0;
      r.byte_position = '0;
      restart_attempt();
      return r;
    end
    case (fr_phase)
      FP_HUNT: begin
        if (b == reg_cfg.start_code) begin
          frame_pos = '0;
          run_sum   = '0;
          kept      = 1'b1;
          fr_phase  = FP_TYPE;
        end else begin
          st = ST_HUNTING;
        end
      end
      FP_TYPE: begin
        // a wrong type byte is dropped, not retried as a start byte
        if (b == reg_cfg.meter_type) begin
          kept     = 1'b1;
          addr_cnt = '0;
          fr_phase = FP_ADDR;
        end else begin
          st       = ST_HUNTING;
          fr_phase = FP_HUNT;
        end
      end
      FP_ADDR: begin
        kept     = 1'b1;
        addr_cnt = addr_cnt + 4'd1;
        if (addr_cnt >= ADDR_BYTES_DEF) fr_phase = FP_CTRL;
      end
      FP_CTRL: begin
        kept     = 1'b1;
        fr_phase = FP_LEN;
      end
      FP_LEN: begin
        kept     = 1'b1;
        data_len = b;
        data_cnt = '0;
        if (b != 8'd0) fr_phase = FP_DATA;
        else fr_phase = FP_CSUM;
      end
      FP_DATA: begin
        kept     = 1'b1;
        data_cnt = data_cnt + 9'd1;
        if (data_cnt >= {1'b0, data_len}) fr_phase = FP_CSUM;
      end
      FP_CSUM: begin
        // the checksum byte is stored but not summed
        pos       = frame_pos;
        frame_pos = frame_pos + 9'd1;
        stored    = 1'b1;
        if (b == run_sum) begin
          fr_phase = FP_END;
        end else begin
          st       = ST_RESYNC;
          fr_phase = FP_HUNT;
        end
      end
      default: begin
        pos    = frame_pos;
        stored = 1'b1;
        done   = 1'b1;
        if (b == reg_cfg.end_code) st = ST_ACCEPTED;
        else st = ST_BAD_END;
      end
    endcase
    if (kept) begin
      pos       = frame_pos;
      frame_pos = frame_pos + 9'd1;
      run_sum   = run_sum + b;
      stored    = 1'b1;
    end
    if (st == ST_HUNTING) begin
      stored = 1'b0;
      pos    = '0;
    end
    // the byte that spends the last budget unit ends the attempt unless it already did
    if (!done) begin
      if (budget_left <= 16'd1) begin
        st   = ST_BUDGET_OUT;
        done = 1'b1;
      end else begin
        budget_left = budget_left - 16'd1;
      end
    end
    if (done) restart_attempt();
    r.status        = st;
    r.frame_byte    = b;
    r.byte_in_frame = stored;
    r.byte_position = pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] nonzero8();
    return 8'($urandom_range(1, 255));
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // data length: mostly short, a few near the maximum
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 12);
    if (r < 98) return $urandom_range(13, 64);
    return $urandom_range(200, 255);
  endfunction

  task automatic push_rx(input logic kind, input logic [7:0] data);
    rx_item_t it;
    it.kind = kind;
    it.data = data;
    rx_pending.push_back(it);
    n_queued++;
  endtask

  // one reply frame under the current register values, possibly damaged
  task automatic queue_frame(input frame_fault_e fault, input int unsigned len);
    logic [7:0]  bytes[$];
    logic [7:0]  sum;
    int unsigned keep;
    bytes.push_back(reg_cfg.start_code);
    if (fault == FR_BAD_TYPE) begin
      bytes.push_back(reg_cfg.meter_type ^ nonzero8());
    end else begin
      bytes.push_back(reg_cfg.meter_type);
      // address bytes and the control byte
      repeat (ADDR_BYTES_DEF + 1) bytes.push_back(rand8());
      bytes.push_back(len[7:0]);
      repeat (len) bytes.push_back(rand8());
      sum = '0;
      foreach (bytes[i]) sum = sum + bytes[i];
      bytes.push_back(fault == FR_BAD_SUM ? sum ^ nonzero8() : sum);
      bytes.push_back(fault == FR_BAD_END ? reg_cfg.end_code ^ nonzero8()
                                          : reg_cfg.end_code);
    end
    keep = (fault == FR_CUT) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    for (int i = 0; i < keep; i++) push_rx(KIND_BYTE, bytes[i]);
    // a cut frame is closed by a timeout carrying junk data
    if (fault == FR_CUT) push_rx(KIND_TIMEOUT, rand8());
  endtask

  // mostly well formed frames, the rest broken frames and line noise
  task automatic queue_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned r;
    int unsigned len;
    stop = n_queued + n;
    while (n_queued < stop) begin
      r   = $urandom_range(0, 99);
      len = pick_len();
      if (r < 12) repeat ($urandom_range(1, 5)) push_rx(KIND_BYTE, rand8());
      else if (r < 15) push_rx(KIND_TIMEOUT, rand8());
      else if (r < 65) queue_frame(FR_GOOD, len);
      else if (r < 75) queue_frame(FR_BAD_SUM, len);
      else if (r < 84) queue_frame(FR_BAD_END, len);
      else if (r < 92) queue_frame(FR_BAD_TYPE, len);
      else queue_frame(FR_CUT, len);
    end
  endtask

  // register write, only issued while nothing is in flight
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_METER_TYPE:  reg_cfg.meter_type  = val[7:0];
      CFG_START_CODE:  reg_cfg.start_code  = val[7:0];
      CFG_END_CODE:    reg_cfg.end_code    = val[7:0];
      CFG_BYTE_BUDGET: reg_cfg.byte_budget = val;
      default: ;
    endcase
  endtask

  // wait until every queued transaction has come back, then let the pipe settle
  task automatic drain();
    while (rx_pending.size() != 0 || in_flight != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_err++;
      if (n_err <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: sends rx_pending, predicts each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= '0;
      s_tuser_i  <= KIND_BYTE;
    end else begin
      if (s_tvalid_i && s_tready_o)
        expected_res.push_back(parse_rx(s_tuser_i, s_tdata_i));
      // the bus is free when nothing is offered or the offer was just taken
      if (!s_tvalid_i || s_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid_i <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          next_rx = rx_pending.pop_front();
          in_flight++;
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= next_rx.data;
          s_tuser_i  <= next_rx.kind;
          send_gap   = idle_len();
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  res_t got_res;
  res_t want_res;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        got_res.status        = status_e'(m_tuser_o[2:0]);
        got_res.byte_in_frame = m_tuser_o[3];
        got_res.frame_byte    = m_tdata_o[7:0];
        got_res.byte_position = m_tdata_o[16:8];
        if (expected_res.size() == 0) begin
          n_err++;
          if (n_err <= MAX_SHOWN)
            $display("%0t: result with nothing expected, expected none actual status %0d byte %0h",
                     $time, got_res.status, got_res.frame_byte);
        end else begin
          want_res = expected_res.pop_front();
          in_flight--;
          n_checked++;
          n_status[want_res.status]++;
          check_field("status", want_res.status, got_res.status);
          check_field("frame_byte", want_res.frame_byte, got_res.frame_byte);
          check_field("byte_in_frame", want_res.byte_in_frame, got_res.byte_in_frame);
          check_field("byte_position", want_res.byte_position, got_res.byte_position);
        end
      end
      // receiver back-pressure
      if (stall_left > 0) begin
        stall_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [7:0]  mt;
    logic [7:0]  sc;
    logic [7:0]  ec;
    logic [15:0] bb;
    restart_attempt();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset register values
    push_rx(KIND_BYTE, 8'h00);                  // noise while hunting
    push_rx(KIND_BYTE, 8'hFF);
    push_rx(KIND_BYTE, reg_cfg.start_code);     // start, then start again as
    push_rx(KIND_BYTE, reg_cfg.start_code);     // a wrong type byte
    push_rx(KIND_TIMEOUT, 8'hFF);               // timeout with data ignored
    queue_frame(FR_GOOD, 0);                    // zero length frame
    drain();
    // zero budget acts as one, and only after the next attempt starts
    write_reg(CFG_BYTE_BUDGET, 16'd0);
    push_rx(KIND_BYTE, reg_cfg.start_code);
    push_rx(KIND_TIMEOUT, 8'h00);
    push_rx(KIND_BYTE, reg_cfg.start_code);
    push_rx(KIND_BYTE, 8'h5A);
    drain();

    // random part, one register setting per phase, the extremes first
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin mt = 8'd0;   sc = 8'd255; ec = 8'd0;   bb = 16'd65535; end
        1: begin mt = 8'd255; sc = 8'd0;   ec = 8'd255; bb = 16'd1;     end
        2: begin
          mt = METER_TYPE_RST;
          sc = START_CODE_RST;
          ec = END_CODE_RST;
          bb = 16'd40;
        end
        default: begin
          mt = rand8();
          sc = rand8();
          ec = rand8();
          bb = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(15, 60))
                                            : 16'($urandom_range(100, 65535));
        end
      endcase
      write_reg(CFG_METER_TYPE, {8'd0, mt});
      write_reg(CFG_START_CODE, {8'd0, sc});
      write_reg(CFG_END_CODE, {8'd0, ec});
      write_reg(CFG_BYTE_BUDGET, bb);
      n_settings++;
      calm = (p % 3 == 2);
      if (p == 0) queue_frame(FR_GOOD, 255);    // longest frame once
      queue_traffic(p == 0 ? 180 : (p == 1 ? 30 : 125));
      drain();
    end

    repeat (LATENCY) @(posedge clk_i);
    $display("checked %0d results under %0d register settings", n_checked, n_settings);
    $display("accepted %0d, resync %0d, bad end %0d, budget out %0d, timeout %0d",
             n_status[ST_ACCEPTED], n_status[ST_RESYNC], n_status[ST_BAD_END],
             n_status[ST_BUDGET_OUT], n_status[ST_TIMEOUT]);
    if (n_err == 0 && expected_res.size() == 0) begin
      $display("PASS cj188_frame_receiver_unit");
    end else begin
      $display("FAIL cj188_frame_receiver_unit");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("FAIL cj188_frame_receiver_unit");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cj188_fr_pkg.sv
rtl/core/cj188_fr_cfg.sv
rtl/core/cj188_fr_parser.sv
rtl/core/cj188_frame_receiver_unit.sv
sim/tb.sv
